// ===== design/lpr_pkg.sv =====
// Package for the LRU page replacement block: widths, limits, controller states
// and the command bundle between controller and datapath. No dependencies.
package lpr_pkg;

   localparam int FRAMES_DEFAULT = 3;
   localparam int PAGE_W         = 16;
   localparam int SLOT_W         = 3;
   localparam int RANK_W         = 3;
   localparam int COUNT_W        = 16;

   localparam logic [RANK_W-1:0]  RANK_MAX  = 3'd7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } lpr_state_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic commit;
   } lpr_cmd_type;

endpackage

// ===== design/lpr_req_if.sv =====
// Request channel: one page reference with a valid/ready handshake.
// Depends on lpr_pkg.
interface lpr_req_if;
   import lpr_pkg::*;

   logic     valid;
   logic     ready;
   page_type page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

// ===== design/lpr_rsp_if.sv =====
// Response channel: outcome of one page reference with a valid/ready handshake.
// Depends on lpr_pkg.
interface lpr_rsp_if;
   import lpr_pkg::*;

   logic      valid;
   logic      ready;
   logic      is_fault;
   slot_type  frame_slot;
   logic      evicted_valid;
   page_type  evicted_page;
   count_type fault_total;

   modport source (output valid, output is_fault, output frame_slot, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink (input valid, input is_fault, input frame_slot, input evicted_valid,
                 input evicted_page, input fault_total, output ready);
endinterface

// ===== design/lpr_ctrl.sv =====
// Controller for the LRU page replacement block: sequences capture, search and
// commit of one request and owns the response valid flag. Depends on lpr_pkg.
module lpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_ready,
   output logic                req_ready,
   output logic                rsp_valid,
   output lpr_pkg::lpr_cmd_type cmd
);
   import lpr_pkg::*;

   lpr_state_type state_ff;
   lpr_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          can_commit;

   // The result register is free when empty or being emptied this cycle.
   assign can_commit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (can_commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = can_commit;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lpr_datapath.sv =====
// Datapath for the LRU page replacement block: frame table, recency ranks,
// search registers, fault counter and result register. Depends on lpr_pkg.
module lpr_datapath #(
   parameter int FRAMES = lpr_pkg::FRAMES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpr_pkg::lpr_cmd_type cmd,
   input  lpr_pkg::page_type    req_page,
   output logic                 rsp_is_fault,
   output lpr_pkg::slot_type    rsp_frame_slot,
   output logic                 rsp_evicted_valid,
   output lpr_pkg::page_type    rsp_evicted_page,
   output lpr_pkg::count_type   rsp_fault_total
);
   import lpr_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   // Frame table and counter.
   page_type          frame_page_ff [FRAMES];
   logic [FRAMES-1:0] frame_valid_ff;
   rank_type          rank_ff [FRAMES];
   count_type         fault_count_ff;

   page_type          frame_page_in [FRAMES];
   logic [FRAMES-1:0] frame_valid_in;
   rank_type          rank_in [FRAMES];
   count_type         fault_count_in;

   // Captured request and search results.
   page_type          page_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              empty_ff;
   logic [IDX_W-1:0]  empty_idx_ff;
   logic [IDX_W-1:0]  victim_idx_ff;

   logic              hit_in;
   logic [IDX_W-1:0]  hit_idx_in;
   logic              empty_in;
   logic [IDX_W-1:0]  empty_idx_in;
   logic [IDX_W-1:0]  victim_idx_in;

   // Result register.
   logic              out_fault_ff;
   slot_type          out_slot_ff;
   logic              out_evict_ff;
   page_type          out_evict_page_ff;

   logic              out_fault_in;
   slot_type          out_slot_in;
   logic              out_evict_in;
   page_type          out_evict_page_in;

   // Search: first matching frame, first empty frame, oldest valid frame.
   always_comb begin
      logic     victim_found;
      rank_type victim_rank;
      hit_in        = 1'b0;
      hit_idx_in    = '0;
      empty_in      = 1'b0;
      empty_idx_in  = '0;
      victim_idx_in = '0;
      victim_found  = 1'b0;
      victim_rank   = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (frame_valid_ff[i] && frame_page_ff[i] == page_ff && !hit_in) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_W'(i);
         end
         if (!frame_valid_ff[i] && !empty_in) begin
            empty_in     = 1'b1;
            empty_idx_in = IDX_W'(i);
         end
         if (frame_valid_ff[i] && (!victim_found || rank_ff[i] > victim_rank)) begin
            victim_found  = 1'b1;
            victim_rank   = rank_ff[i];
            victim_idx_in = IDX_W'(i);
         end
      end
   end

   // Commit: rank ageing, frame fill or replacement, result fields.
   always_comb begin
      logic [IDX_W-1:0] target;
      rank_type         hit_rank;
      target   = empty_ff ? empty_idx_ff : victim_idx_ff;
      hit_rank = rank_ff[hit_idx_ff];
      for (int i = 0; i < FRAMES; i++) begin
         frame_page_in[i] = frame_page_ff[i];
         rank_in[i]       = rank_ff[i];
      end
      frame_valid_in    = frame_valid_ff;
      fault_count_in    = fault_count_ff;
      out_fault_in      = 1'b0;
      out_slot_in       = '0;
      out_evict_in      = 1'b0;
      out_evict_page_in = '0;
      if (hit_ff) begin
         // Only frames younger than the hit frame grow older.
         for (int i = 0; i < FRAMES; i++) begin
            if (IDX_W'(i) != hit_idx_ff && frame_valid_ff[i] && rank_ff[i] < hit_rank
                && rank_ff[i] != RANK_MAX) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         rank_in[hit_idx_ff] = '0;
         out_slot_in         = SLOT_W'(hit_idx_ff);
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            if (IDX_W'(i) != target && frame_valid_ff[i] && rank_ff[i] != RANK_MAX) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         if (!empty_ff) begin
            out_evict_in      = 1'b1;
            out_evict_page_in = frame_page_ff[target];
         end
         frame_page_in[target]  = page_ff;
         frame_valid_in[target] = 1'b1;
         rank_in[target]        = '0;
         out_fault_in           = 1'b1;
         out_slot_in            = SLOT_W'(target);
         if (fault_count_ff != COUNT_MAX) fault_count_in = fault_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         fault_count_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         frame_valid_ff <= frame_valid_in;
         fault_count_ff <= fault_count_in;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) page_ff <= req_page;
      if (cmd.search) begin
         hit_ff        <= hit_in;
         hit_idx_ff    <= hit_idx_in;
         empty_ff      <= empty_in;
         empty_idx_ff  <= empty_idx_in;
         victim_idx_ff <= victim_idx_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < FRAMES; i++) begin
            frame_page_ff[i] <= frame_page_in[i];
         end
         out_fault_ff      <= out_fault_in;
         out_slot_ff       <= out_slot_in;
         out_evict_ff      <= out_evict_in;
         out_evict_page_ff <= out_evict_page_in;
      end
   end

   assign rsp_is_fault      = out_fault_ff;
   assign rsp_frame_slot    = out_slot_ff;
   assign rsp_evicted_valid = out_evict_ff;
   assign rsp_evicted_page  = out_evict_page_ff;
   assign rsp_fault_total   = fault_count_ff;

endmodule

// ===== design/lru_page_replacement.sv =====
// LRU page replacement block: controller and datapath behind request/response channels.
// A response is registered by the commit step, which follows the capture and search steps.
// A new request is taken only once the previous one is committed; the capture, search and commit steps of
// the controller run one after another, and commit waits while the result register is full.
// Reset: synchronous; all frames invalid, ranks and fault count zero, no clearing pass.
module lru_page_replacement #(
   parameter int FRAMES = lpr_pkg::FRAMES_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   lpr_req_if.sink   req_chan,
   lpr_rsp_if.source rsp_chan
);
   import lpr_pkg::*;

   lpr_cmd_type cmd;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   lpr_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_page          (req_chan.page_number),
      .rsp_is_fault      (rsp_chan.is_fault),
      .rsp_frame_slot    (rsp_chan.frame_slot),
      .rsp_evicted_valid (rsp_chan.evicted_valid),
      .rsp_evicted_page  (rsp_chan.evicted_page),
      .rsp_fault_total   (rsp_chan.fault_total)
   );

   // Once a request is taken the block is busy with it for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while the previous one was still in the search step");

   // Only a fault can evict a page.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.evicted_valid |-> rsp_chan.is_fault)
      else $error("eviction reported on a hit");

   // A response with no eviction carries a zero evicted page.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.evicted_valid |-> rsp_chan.evicted_page == '0)
      else $error("evicted page not zero without an eviction");

   // A new response only appears after the commit step has run.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

endmodule
